// File: src/rgbled_pkg.sv
// Package for the RGB LED bit encoder: transaction structs, register indexes,
// the basic color table and the channel scaling function.
// Has no dependencies.
package rgbled_pkg;

   localparam int BitsPerWord = 24;
   localparam int CountWidth = $clog2(BitsPerWord);
   localparam int CsrIndexWidth = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_ONE_HIGH_TICKS = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ONE_LOW_TICKS = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ZERO_HIGH_TICKS = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ZERO_LOW_TICKS = 8'd3;

   localparam logic [7:0] ONE_HIGH_RESET = 8'd4;
   localparam logic [7:0] ONE_LOW_RESET = 8'd3;
   localparam logic [7:0] ZERO_HIGH_RESET = 8'd1;
   localparam logic [7:0] ZERO_LOW_RESET = 8'd6;

   typedef struct packed {
      logic [2:0] color_index;
      logic [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic       bit_value;
      logic [7:0] high_ticks;
      logic [7:0] low_ticks;
      logic       last_bit;
   } rsp_type;

   typedef struct packed {
      logic [1:0] red;
      logic [1:0] green;
      logic [1:0] blue;
      logic [1:0] divider;
   } color_entry_type;

   localparam color_entry_type ColorTable [8] = '{
      '{red: 2'd1, green: 2'd0, blue: 2'd0, divider: 2'd1},
      '{red: 2'd0, green: 2'd1, blue: 2'd0, divider: 2'd1},
      '{red: 2'd0, green: 2'd0, blue: 2'd1, divider: 2'd1},
      '{red: 2'd1, green: 2'd1, blue: 2'd1, divider: 2'd1},
      '{red: 2'd0, green: 2'd1, blue: 2'd1, divider: 2'd1},
      '{red: 2'd1, green: 2'd1, blue: 2'd0, divider: 2'd1},
      '{red: 2'd1, green: 2'd1, blue: 2'd2, divider: 2'd2},
      '{red: 2'd2, green: 2'd1, blue: 2'd1, divider: 2'd2}
   };

   // The divider is always one or two, so the division is a shift.
   function automatic logic [7:0] scale_channel(logic [1:0] weight, logic [1:0] divider,
                                                logic [7:0] level);
      logic [9:0] product;
      logic [9:0] quotient;
      product = 10'(weight) * 10'(level);
      quotient = (divider == 2'd2) ? (product >> 1) : product;
      return (quotient > 10'd255) ? 8'hFF : quotient[7:0];
   endfunction

   // The word is sent green, red, blue, most significant bit first.
   function automatic logic [BitsPerWord-1:0] color_word(req_type req);
      color_entry_type entry;
      entry = ColorTable[req.color_index];
      return {scale_channel(entry.green, entry.divider, req.brightness),
              scale_channel(entry.red, entry.divider, req.brightness),
              scale_channel(entry.blue, entry.divider, req.brightness)};
   endfunction

endpackage

// File: src/rgb_led_bit_encoder.sv
// Top level of the RGB LED bit encoder: a one-deep command buffer, the bit
// shifter, the timing registers and the result register.
// Depends on rgbled_pkg.
//
// A command transaction (color index and brightness) is taken at a rising
// edge with start high and busy low. The color word is formed at once and
// held in a one-entry buffer; busy is high while that buffer is full.
// The shifter takes the buffered word when it is empty or on its last bit,
// so words follow each other with no gap. Each word gives 24 result
// transactions, green, red, blue, most significant bit first, one per
// cycle on rsp with rsp_valid high; last_bit marks the 24th.
// When the shifter is idle, a taken command passes through the buffer and
// the shifter to the result register. The buffer takes a new command while
// the shifter is still sending the previous word, one bit per cycle.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Timing registers are written on the csr channel, which is always ready;
// writes to unknown indexes are dropped. Reset empties the buffer and the
// shifter and loads the default pulse lengths.
module rgb_led_bit_encoder
   import rgbled_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req,
   output logic                     rsp_valid,
   output rsp_type                  rsp,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_data
);

   logic [7:0] one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;
   logic [7:0] one_high_in, one_low_in, zero_high_in, zero_low_in;

   logic                   pend_valid_ff, pend_valid_in;
   logic [BitsPerWord-1:0] pend_word_ff, pend_word_in;

   logic                   sh_active_ff, sh_active_in;
   logic [BitsPerWord-1:0] sh_word_ff, sh_word_in;
   logic [CountWidth-1:0]  sh_count_ff, sh_count_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic sh_last;
   logic sh_free;
   logic cur_bit;

   assign csr_ready = 1'b1;
   assign busy = pend_valid_ff;
   assign accept = start && !pend_valid_ff;
   assign sh_last = sh_active_ff && (sh_count_ff == CountWidth'(BitsPerWord - 1));
   assign sh_free = !sh_active_ff || sh_last;
   assign cur_bit = sh_word_ff[BitsPerWord-1];

   always_comb begin
      one_high_in = one_high_ff;
      one_low_in = one_low_ff;
      zero_high_in = zero_high_ff;
      zero_low_in = zero_low_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ONE_HIGH_TICKS:  one_high_in = csr_data;
            CSR_ONE_LOW_TICKS:   one_low_in = csr_data;
            CSR_ZERO_HIGH_TICKS: zero_high_in = csr_data;
            CSR_ZERO_LOW_TICKS:  zero_low_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_word_in = pend_word_ff;
      sh_active_in = sh_active_ff;
      sh_word_in = sh_word_ff;
      sh_count_in = sh_count_ff;

      if (sh_active_ff) begin
         sh_word_in = {sh_word_ff[BitsPerWord-2:0], 1'b0};
         sh_count_in = sh_count_ff + CountWidth'(1);
      end
      if (sh_last) begin
         sh_active_in = 1'b0;
      end
      if (sh_free && pend_valid_ff) begin
         sh_active_in = 1'b1;
         sh_word_in = pend_word_ff;
         sh_count_in = '0;
         pend_valid_in = 1'b0;
      end
      if (accept) begin
         pend_valid_in = 1'b1;
         pend_word_in = color_word(req);
      end

      rsp_valid_in = sh_active_ff;
      rsp_in.bit_value = cur_bit;
      rsp_in.high_ticks = cur_bit ? one_high_ff : zero_high_ff;
      rsp_in.low_ticks = cur_bit ? one_low_ff : zero_low_ff;
      rsp_in.last_bit = sh_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff <= ONE_HIGH_RESET;
         one_low_ff <= ONE_LOW_RESET;
         zero_high_ff <= ZERO_HIGH_RESET;
         zero_low_ff <= ZERO_LOW_RESET;
         pend_valid_ff <= 1'b0;
         sh_active_ff <= 1'b0;
         sh_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         one_high_ff <= one_high_in;
         one_low_ff <= one_low_in;
         zero_high_ff <= zero_high_in;
         zero_low_ff <= zero_low_in;
         pend_valid_ff <= pend_valid_in;
         sh_active_ff <= sh_active_in;
         sh_count_ff <= sh_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_word_ff <= pend_word_in;
      sh_word_ff <= sh_word_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule
